// ===== rtl/core/kms_pkg.sv =====
// Shared types, constants and helper functions of the keypad matrix scanner.
`timescale 1ns / 1ps

package kms_pkg;

   // Default number of entries in the downstream key buffer.
   localparam int KMS_BUFFER_DEPTH = 16;

   // Reset values of the configuration registers.
   localparam logic [15:0] DEBOUNCE_RESET = 16'd10;
   localparam logic [15:0] SCAN_GAP_RESET = 16'd10;
   localparam logic [15:0] HOLDOFF_RESET  = 16'd200;

   // Configuration register indexes (word address bits).
   localparam logic [1:0] REG_DEBOUNCE = 2'd0;
   localparam logic [1:0] REG_SCAN_GAP = 2'd1;
   localparam logic [1:0] REG_HOLDOFF  = 2'd2;

   // Scan phase codes.
   localparam logic [2:0] PH_SCAN     = 3'd0;
   localparam logic [2:0] PH_DEBOUNCE = 3'd1;
   localparam logic [2:0] PH_RELEASE  = 3'd2;
   localparam logic [2:0] PH_HOLDOFF  = 3'd3;
   localparam logic [2:0] PH_GAP      = 3'd4;

   // Row and column line constants.
   localparam logic [3:0] ROWS_IDLE   = 4'hF;
   localparam logic [3:0] DRIVE_NONE  = 4'hF;
   localparam logic [1:0] LAST_COLUMN = 2'd3;

   // ASCII bases for the hex digit of a key code.
   localparam logic [6:0] CHAR_ZERO   = 7'd48;
   localparam logic [6:0] CHAR_LETTER = 7'd55;
   localparam logic [3:0] FIRST_LETTER_CODE = 4'd10;

   // Payload of one request: the sampled row lines.
   typedef struct packed {
      logic [3:0] row_lines;
   } kms_req_type;

   // Payload of one result.
   typedef struct packed {
      logic [3:0] column_drive;
      logic       key_valid;
      logic [3:0] key_code;
      logic [6:0] key_char;
      logic [3:0] key_index;
      logic       multi_press;
   } kms_rsp_type;

   // Configuration register contents.
   typedef struct packed {
      logic [15:0] debounce_ticks;
      logic [15:0] scan_gap_ticks;
      logic [15:0] holdoff_ticks;
   } kms_cfg_type;

   // Decoded latched row pattern.
   typedef struct packed {
      logic       single;
      logic [1:0] row;
   } kms_row_type;

   // A latched pattern is a single key only when exactly one row is low.
   function automatic kms_row_type kms_row_decode(input logic [3:0] held);
      kms_row_type result;
      result = '0;
      case (held)
         4'hE: begin
            result.single = 1'b1;
            result.row    = 2'd0;
         end
         4'hD: begin
            result.single = 1'b1;
            result.row    = 2'd1;
         end
         4'hB: begin
            result.single = 1'b1;
            result.row    = 2'd2;
         end
         4'h7: begin
            result.single = 1'b1;
            result.row    = 2'd3;
         end
         default: begin
            result.single = 1'b0;
            result.row    = 2'd0;
         end
      endcase
      return result;
   endfunction

   // ASCII hex digit of a key code: '0' to '9', then 'A' to 'F'.
   function automatic logic [6:0] kms_hex_char(input logic [3:0] code);
      logic [6:0] result;
      if (code < FIRST_LETTER_CODE) begin
         result = CHAR_ZERO + {3'd0, code};
      end else begin
         result = CHAR_LETTER + {3'd0, code};
      end
      return result;
   endfunction

endpackage

// ===== rtl/core/kms_stream_if.sv =====
// Valid/ready channel interface carrying one request or result payload.
`timescale 1ns / 1ps

interface kms_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/kms_csr.sv =====
// APB-style configuration registers of the keypad matrix scanner.
`timescale 1ns / 1ps

module kms_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output kms_pkg::kms_cfg_type cfg
);
   import kms_pkg::*;

   logic [1:0]  reg_index;
   logic        write_strobe;
   kms_cfg_type cfg_ff;
   kms_cfg_type cfg_in;

   // The port never inserts wait states.
   assign pready       = 1'b1;
   assign reg_index    = paddr[3:2];
   assign write_strobe = psel & penable & pwrite;

   // Register write decode; writes beyond the last register are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_strobe) begin
         case (reg_index)
            REG_DEBOUNCE: cfg_in.debounce_ticks = pwdata[15:0];
            REG_SCAN_GAP: cfg_in.scan_gap_ticks = pwdata[15:0];
            REG_HOLDOFF:  cfg_in.holdoff_ticks  = pwdata[15:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= DEBOUNCE_RESET;
         cfg_ff.scan_gap_ticks <= SCAN_GAP_RESET;
         cfg_ff.holdoff_ticks  <= HOLDOFF_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read data multiplexer.
   always_comb begin
      case (reg_index)
         REG_DEBOUNCE: prdata = {16'd0, cfg_ff.debounce_ticks};
         REG_SCAN_GAP: prdata = {16'd0, cfg_ff.scan_gap_ticks};
         REG_HOLDOFF:  prdata = {16'd0, cfg_ff.holdoff_ticks};
         default:      prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/kms_scan_fsm.sv =====
// Scan state machine: one state update and one result per registered request.
`timescale 1ns / 1ps

module kms_scan_fsm #(
   parameter int BUFFER_DEPTH = kms_pkg::KMS_BUFFER_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [3:0]           rows,
   input  kms_pkg::kms_cfg_type cfg,
   output kms_pkg::kms_rsp_type result
);
   import kms_pkg::*;

   localparam int KeyCountWidth = $clog2(BUFFER_DEPTH);

   logic [1:0]               column_ff, column_in;
   logic [2:0]               phase_ff, phase_in;
   logic [15:0]              wait_ff, wait_in;
   logic [3:0]               held_ff, held_in;
   logic [KeyCountWidth-1:0] count_ff, count_in;

   logic [15:0] wait_dec;
   logic [2:0]  gap_phase;
   kms_row_type held_row;
   logic [3:0]  code;

   assign wait_dec  = (wait_ff != 16'd0) ? (wait_ff - 16'd1) : wait_ff;
   assign gap_phase = (cfg.scan_gap_ticks != 16'd0) ? PH_GAP : PH_SCAN;
   assign held_row  = kms_row_decode(held_ff);
   assign code      = {held_row.row, column_ff};

   // Next state and result for the current row sample.
   always_comb begin
      column_in = column_ff;
      phase_in  = phase_ff;
      wait_in   = wait_ff;
      held_in   = held_ff;
      count_in  = count_ff;
      result    = '0;

      case (phase_ff)
         PH_SCAN: begin
            if (rows != ROWS_IDLE) begin
               wait_in  = cfg.debounce_ticks;
               phase_in = PH_DEBOUNCE;
            end else if (column_ff == LAST_COLUMN) begin
               wait_in   = cfg.scan_gap_ticks;
               column_in = 2'd0;
               phase_in  = gap_phase;
            end else begin
               column_in = column_ff + 2'd1;
            end
         end
         PH_DEBOUNCE: begin
            if (wait_ff != 16'd0) begin
               wait_in = wait_dec;
            end else if (rows == ROWS_IDLE) begin
               // False press: carry on with the next column.
               if (column_ff == LAST_COLUMN) begin
                  wait_in   = cfg.scan_gap_ticks;
                  column_in = 2'd0;
                  phase_in  = gap_phase;
               end else begin
                  column_in = column_ff + 2'd1;
                  phase_in  = PH_SCAN;
               end
            end else begin
               held_in  = rows;
               phase_in = PH_RELEASE;
            end
         end
         PH_RELEASE: begin
            if (rows == ROWS_IDLE) begin
               held_in = ROWS_IDLE;
               if (held_row.single) begin
                  result.key_valid = 1'b1;
                  result.key_code  = code;
                  result.key_char  = kms_hex_char(code);
                  result.key_index = 4'(count_ff);
                  count_in = (count_ff == KeyCountWidth'(BUFFER_DEPTH - 1)) ?
                             '0 : count_ff + KeyCountWidth'(1);
                  column_in = 2'd0;
                  if (cfg.holdoff_ticks != 16'd0) begin
                     wait_in  = cfg.holdoff_ticks;
                     phase_in = PH_HOLDOFF;
                  end else begin
                     wait_in  = cfg.scan_gap_ticks;
                     phase_in = gap_phase;
                  end
               end else begin
                  // Several rows were low: reject and go to the gap, or straight to scanning when the gap is zero.
                  result.multi_press = 1'b1;
                  wait_in   = cfg.scan_gap_ticks;
                  column_in = 2'd0;
                  phase_in  = gap_phase;
               end
            end
         end
         PH_HOLDOFF: begin
            wait_in = wait_dec;
            if (wait_dec == 16'd0) begin
               wait_in   = cfg.scan_gap_ticks;
               column_in = 2'd0;
               phase_in  = gap_phase;
            end
         end
         PH_GAP: begin
            wait_in = wait_dec;
            if (wait_dec == 16'd0) begin
               column_in = 2'd0;
               phase_in  = PH_SCAN;
            end
         end
         default: begin
            column_in = 2'd0;
            phase_in  = PH_SCAN;
            wait_in   = 16'd0;
            held_in   = ROWS_IDLE;
         end
      endcase

      // Column drive for the next sample; none during idle waits.
      if (phase_in == PH_HOLDOFF || phase_in == PH_GAP) begin
         result.column_drive = DRIVE_NONE;
      end else begin
         result.column_drive = ~(4'b0001 << column_in);
      end
   end

   // State advances only when the registered request moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= 2'd0;
         phase_ff  <= PH_SCAN;
         wait_ff   <= 16'd0;
         held_ff   <= ROWS_IDLE;
         count_ff  <= '0;
      end else if (advance) begin
         column_ff <= column_in;
         phase_ff  <= phase_in;
         wait_ff   <= wait_in;
         held_ff   <= held_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/keypad_matrix_scanner_unit.sv =====
// Top level of the keypad matrix scanner: request and result registers around the scan logic.
`timescale 1ns / 1ps

// Scans a 4x4 active-low key matrix, one row sample per request, and returns
// one result per request: the column to drive next, and on release of a
// debounced single key its code, hex character and buffer index, or a flag
// for a rejected multi-row press. The block takes one request every clock
// cycle while the result register is not stalled. Each accepted request is
// registered, the scan state machine then updates once, and the result
// lands in an output register. A stalled result register holds the
// pipeline; new requests are still taken while a result waits, as long as
// the request register is empty. The user writes the configuration
// registers through the APB-style port only while no request is in flight;
// the block itself does not enforce this.

module keypad_matrix_scanner_unit #(
   parameter int BUFFER_DEPTH = kms_pkg::KMS_BUFFER_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   kms_stream_if.sink   req_if,
   kms_stream_if.source rsp_if,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import kms_pkg::*;

   kms_cfg_type cfg;
   kms_rsp_type result;
   logic        advance;

   logic        in_valid_ff, in_valid_in;
   logic [3:0]  in_rows_ff, in_rows_in;
   logic        out_valid_ff, out_valid_in;
   kms_rsp_type out_ff, out_in;

   kms_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   kms_scan_fsm #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_scan_fsm (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rows    (in_rows_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // The registered request moves on when the result register can take it.
   assign advance      = in_valid_ff & (~out_valid_ff | rsp_if.ready);
   assign req_if.ready = ~in_valid_ff | advance;

   // Request register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_rows_in  = in_rows_ff;
      if (req_if.ready) begin
         in_valid_in = req_if.valid;
         in_rows_in  = req_if.payload.row_lines;
      end
   end

   // Result register.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_rows_ff <= in_rows_in;
      out_ff     <= out_in;
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_ff;

   // A held request keeps its row sample until it moves on.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_rows_ff)))
      else $error("request register lost or changed a stalled request");

   // With the result register empty, a request can always be taken.
   assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_if.ready)
      else $error("request refused while the result register is empty");

   // A result drives at most one column.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> ($countones(rsp_if.payload.column_drive) >= 3))
      else $error("more than one column driven");

   // A reported key and a rejected press never share a result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !(rsp_if.payload.key_valid && rsp_if.payload.multi_press))
      else $error("key reported and rejected in the same result");

endmodule
